// ===== design/base64_encoder_key_xor_top_macros.svh =====
// ---------------------------------------------------------------------------
// base64_encoder_key_xor_top_macros.svh
// Assertion macros used by the block's checker.
// ---------------------------------------------------------------------------
`ifndef BASE64_ENCODER_KEY_XOR_TOP_MACROS_SVH
`define BASE64_ENCODER_KEY_XOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define B64X_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64x: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define B64X_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64x: next-cycle check failed");

`endif

// ===== design/b64x_pkg.sv =====
// ---------------------------------------------------------------------------
// b64x_pkg
// Shared constants, types and the base64 alphabet for the keyed encoder.
// ---------------------------------------------------------------------------
package b64x_pkg;

    localparam int KEY_SLOTS = 8;
    localparam int KEY_W     = 6;
    localparam int KEY_BITS  = KEY_SLOTS * KEY_W;
    localparam int KPOS_W    = $clog2(KEY_SLOTS);
    localparam int KLEN_W    = 4;
    localparam int MAX_CHARS = 4;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int ADDR_W    = 4;
    localparam int PDATA_W   = 64;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // register select, taken from paddr[3]
    localparam logic REG_KEY_LENGTH = 1'b0;
    localparam logic REG_KEY_DIGITS = 1'b1;

    // position within a 3-byte group
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] key_arr_t;
    typedef logic [MAX_CHARS-1:0][7:0]       char_arr_t;

    typedef struct packed {
        char_arr_t          chars;
        logic [CNT_W-1:0]   cnt;
        logic               last;
        logic [1:0]         phase;
        logic [3:0]         carry;
        logic [KPOS_W-1:0]  key_pos;
    } enc_result_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v} - 8'd26;
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v} - 8'd52;
        else if (v == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

endpackage

// ===== design/base64_encoder_key_xor_top.sv =====
// ---------------------------------------------------------------------------
// base64_encoder_key_xor_top
// Keyed base64 encoder: message bytes in, base64 characters out.
// ---------------------------------------------------------------------------
// Input words (data_byte, last_byte) arrive on in_valid/in_ready, one message
// byte per word, last_byte set on the final byte. Output words (out_char,
// last_char) leave on out_valid/out_ready, one character per word; last_char
// marks the final character of the message, padding included.
// A byte is encoded in the cycle it is accepted into a 4-character holding
// buffer; its first character then moves on into the output register. The
// buffer drains one character per cycle into the output register while the
// receiver takes them, so throughput is set by the output port; a body byte
// yields 1 to 2 characters and the final byte up to 4. A new byte is taken in
// the cycle the last buffered character moves out. If the receiver stalls,
// the output register holds and the buffer fills, then in_ready drops. Reset
// empties the buffer and output, returns group phase and key position to
// zero, key_length to 1 and key_digits to 0. The user must write configuration
// (APB, 64-bit data, key_length at 0x0, key_digits at 0x8) only while the
// encoder is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module base64_encoder_key_xor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_char,
    output logic                          last_char,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [b64x_pkg::ADDR_W-1:0]   paddr,
    input  logic [b64x_pkg::PDATA_W-1:0]  pwdata,
    output logic [b64x_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import b64x_pkg::*;

    logic [KLEN_W-1:0]   key_length_reg;
    logic [KEY_BITS-1:0] key_digits_reg;
    logic [1:0]          phase_reg;
    logic [3:0]          carry_reg;
    logic [KPOS_W-1:0]   key_pos_reg;

    char_arr_t           pend_char_reg;
    char_arr_t           pend_char_next;
    logic [CNT_W-1:0]    pend_cnt_reg;
    logic [CNT_W-1:0]    pend_cnt_next;
    logic                pend_last_reg;
    logic                pend_last_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_char_reg;
    logic                out_last_reg;

    enc_result_t         enc;
    logic                accept;
    logic                move;
    logic                cfg_wr;

    b64x_enc u_enc (
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .phase      (phase_reg),
        .carry      (carry_reg),
        .key_pos    (key_pos_reg),
        .key_length (key_length_reg),
        .key_digits (key_digits_reg),
        .enc        (enc)
    );

    assign move     = (pend_cnt_reg != '0) && (!out_valid_reg || out_ready);
    assign in_ready = (pend_cnt_reg == '0) || ((pend_cnt_reg == CNT_W'(1)) && move);
    assign accept   = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_comb
    begin
        pend_char_next = pend_char_reg;
        pend_cnt_next  = pend_cnt_reg;
        pend_last_next = pend_last_reg;
        if (accept)
        begin
            pend_char_next = enc.chars;
            pend_cnt_next  = enc.cnt;
            pend_last_next = enc.last;
        end
        else if (move)
        begin
            pend_char_next = {8'h00, pend_char_reg[MAX_CHARS-1:1]};
            pend_cnt_next  = pend_cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        if (move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KLEN_W'(1);
            key_digits_reg <= '0;
            phase_reg      <= PH_FIRST;
            carry_reg      <= '0;
            key_pos_reg    <= '0;
            pend_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3])
                    REG_KEY_LENGTH: key_length_reg <= pwdata[KLEN_W-1:0];
                    REG_KEY_DIGITS: key_digits_reg <= pwdata[KEY_BITS-1:0];
                    default:        key_length_reg <= key_length_reg;
                endcase
            end
            if (accept)
            begin
                phase_reg   <= enc.phase;
                carry_reg   <= enc.carry;
                key_pos_reg <= enc.key_pos;
            end
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_char_reg <= pend_char_next;
        pend_last_reg <= pend_last_next;
        if (move)
        begin
            out_char_reg <= pend_char_reg[0];
            out_last_reg <= pend_last_reg && (pend_cnt_reg == CNT_W'(1));
        end
    end

    always_comb
    begin
        case (paddr[3])
            REG_KEY_LENGTH: prdata = PDATA_W'(key_length_reg);
            REG_KEY_DIGITS: prdata = PDATA_W'(key_digits_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = out_last_reg;

endmodule

// ===== design/b64x_enc.sv =====
// ---------------------------------------------------------------------------
// b64x_enc
// One byte in: keyed base64 characters of that byte and the next group state.
// ---------------------------------------------------------------------------
module b64x_enc (
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic [1:0]                    phase,
    input  logic [3:0]                    carry,
    input  logic [b64x_pkg::KPOS_W-1:0]   key_pos,
    input  logic [b64x_pkg::KLEN_W-1:0]   key_length,
    input  logic [b64x_pkg::KEY_BITS-1:0] key_digits,
    output b64x_pkg::enc_result_t         enc
);
    import b64x_pkg::*;

    key_arr_t            key_arr;
    logic [KLEN_W-1:0]   eff_len;
    logic [KPOS_W-1:0]   kp1;
    logic [KPOS_W-1:0]   kp2;
    logic [KEY_W-1:0]    d0;
    logic [KEY_W-1:0]    d1;

    function automatic logic [KPOS_W-1:0] kp_step(input logic [KPOS_W-1:0] kp,
                                                  input logic [KLEN_W-1:0] len);
        logic [KLEN_W-1:0] nx;
        nx = KLEN_W'(kp) + KLEN_W'(1);
        return (nx >= len) ? '0 : nx[KPOS_W-1:0];
    endfunction

    assign key_arr = key_arr_t'(key_digits);

    always_comb
    begin
        if (key_length == '0)
            eff_len = KLEN_W'(1);
        else if (key_length > KLEN_W'(KEY_SLOTS))
            eff_len = KLEN_W'(KEY_SLOTS);
        else
            eff_len = key_length;
    end

    assign kp1 = kp_step(key_pos, eff_len);
    assign kp2 = kp_step(kp1, eff_len);

    always_comb
    begin
        d0 = '0;
        d1 = '0;
        enc.cnt     = CNT_W'(1);
        enc.phase   = PH_FIRST;
        enc.carry   = '0;
        enc.key_pos = kp1;
        case (phase)
            PH_SECOND:
            begin
                d0 = {carry[1:0], data_byte[7:4]};
                d1 = {data_byte[3:0], 2'b00};
                enc.carry = data_byte[3:0];
                enc.phase = PH_THIRD;
                enc.cnt   = last_byte ? CNT_W'(3) : CNT_W'(1);
            end
            PH_THIRD:
            begin
                d0 = {carry, data_byte[7:6]};
                d1 = data_byte[5:0];
                enc.cnt     = CNT_W'(2);
                enc.key_pos = kp2;
            end
            default:
            begin
                d0 = data_byte[7:2];
                d1 = {data_byte[1:0], 4'b0000};
                enc.carry = {2'b00, data_byte[1:0]};
                enc.phase = PH_SECOND;
                enc.cnt   = last_byte ? CNT_W'(4) : CNT_W'(1);
            end
        endcase
        if (last_byte)
        begin
            enc.carry   = '0;
            enc.phase   = PH_FIRST;
            enc.key_pos = '0;
        end
        enc.chars[0] = b64_char(d0 ^ key_arr[key_pos]);
        enc.chars[1] = b64_char(d1 ^ key_arr[kp1]);
        enc.chars[2] = PAD_CHAR;
        enc.chars[3] = PAD_CHAR;
        enc.last     = last_byte;
    end

endmodule

// ===== design/b64x_checker.sv =====
// ---------------------------------------------------------------------------
// b64x_checker
// Port-level checks for the keyed base64 encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "base64_encoder_key_xor_top_macros.svh"

module b64x_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          last_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [7:0]                    out_char,
    input  logic                          last_char,
    input  logic                          psel,
    input  logic                          pready
);
    import b64x_pkg::*;

    // stalled output word holds
    `B64X_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_char) && $stable(last_char))

    // a pad that does not close the message is followed at once by another pad
    `B64X_ASSERT_NEXT(a_pad_run, out_valid && out_ready && out_char == PAD_CHAR && !last_char,
        out_valid && out_char == PAD_CHAR)

    // a final byte yields at least two characters, so the next byte must wait
    `B64X_ASSERT_NEXT(a_last_blocks, in_valid && in_ready && last_byte, !in_ready)

    `B64X_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind base64_encoder_key_xor_top b64x_checker u_b64x_checker (.*);
